@@ rtl/ezr_pkg.sv @@
// Package for the ZYX Euler angle to rotation matrix block: widths, constants, helpers.
package ezr_pkg;

    localparam int ANGLE_WIDTH  = 16;
    localparam int OUT_WIDTH    = 16;
    localparam int CORDIC_ITERS = 24;
    localparam int PH_W         = 32;
    localparam int XY_W         = 34;

    localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [XY_W-1:0] ONE_Q30   = 34'sd1073741824;
    localparam logic signed [XY_W-1:0] NEG_ONE_Q30 = -34'sd1073741824;

    typedef logic signed [ANGLE_WIDTH-1:0] t_angle;
    typedef logic signed [OUT_WIDTH-1:0]   t_q15;
    typedef logic signed [XY_W-1:0]        t_q30;

    typedef struct packed {
        t_q15 m00; t_q15 m01; t_q15 m02;
        t_q15 m10; t_q15 m11; t_q15 m12;
        t_q15 m20; t_q15 m21; t_q15 m22;
    } t_matrix;

    typedef struct packed {
        t_angle roll_angle;
        t_angle pitch_angle;
        t_angle yaw_angle;
    } t_angles;

    function automatic logic signed [PH_W:0] atan_of(input int i);
        logic [31:0] v;
        case (i)
            0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
            3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
            6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
            9: v = 32'h00145F2F;  10: v = 32'h000A2F98; 11: v = 32'h000517CC;
            12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
            15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
            18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
            21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return $signed({1'b0, v});
    endfunction

    // Q2.30 product, rounded to nearest with ties toward plus infinity.
    function automatic t_q30 mul30(input t_q30 a, input t_q30 b);
        logic signed [2*XY_W-1:0] p;
        p = a * b + (68'sd1 <<< 29);
        return t_q30'(p >>> 30);
    endfunction

    function automatic t_q15 to_q15(input t_q30 v);
        logic signed [XY_W-1:0] r;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767) return 16'sd32767;
        if (r < -34'sd32768) return -16'sd32768;
        return t_q15'(r);
    endfunction

endpackage

@@ rtl/ezr_stream_if.sv @@
// Valid/ready stream interface carrying one payload item per handshake.
interface ezr_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/euler_zyx_to_rotation_matrix_top.sv @@
// Top level: pipelined CORDIC sine/cosine and ZYX rotation matrix product.
// Register stages from input accept to output valid: 1 fold, 24 CORDIC, 4 matrix.
// Throughput: one item per cycle; every stage is a register that advances when the
// output register is empty or being read, so a stall freezes the whole pipeline.
// Reset (i_rst_n, synchronous, active low) clears all valid bits; data needs none.
module euler_zyx_to_rotation_matrix_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ezr_stream_if.sink   i_in,
    ezr_stream_if.source o_out
);
    localparam int N  = ezr_pkg::CORDIC_ITERS;
    localparam int NS = N + 5;

    logic adv;
    logic [NS-1:0] r_vld;

    // Stage CORDIC registers for three angles.
    ezr_pkg::t_q30 r_x [3][N+1];
    ezr_pkg::t_q30 r_y [3][N+1];
    logic signed [ezr_pkg::PH_W:0] r_z [3][N+1];
    logic [N:0] r_neg [3];

    ezr_pkg::t_q30 r_s [3], r_c [3];
    ezr_pkg::t_q30 r_p1 [8];
    ezr_pkg::t_q30 r_spr, r_spc, r_nsp, r_sy2, r_cy2;
    ezr_pkg::t_q30 r_t1, r_t2, r_t4, r_t5, r_q [2];
    ezr_pkg::t_q30 r_a [9];
    ezr_pkg::t_matrix r_out;

    assign adv = !o_out.valid || o_out.ready;
    assign i_in.ready = adv;
    assign o_out.valid = r_vld[NS-1];
    assign o_out.data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NS-2:0], i_in.valid};
        end
    end

    genvar a, k;
    generate
        for (a = 0; a < 3; a++) begin : g_ang
            ezr_pkg::t_angle ang;
            logic signed [ezr_pkg::PH_W:0] ph, zf;
            logic nf;
            if (a == 0) begin : g_r
                assign ang = i_in.data.roll_angle;
            end else if (a == 1) begin : g_p
                assign ang = i_in.data.pitch_angle;
            end else begin : g_y
                assign ang = i_in.data.yaw_angle;
            end
            always_comb begin
                ph = (ezr_pkg::PH_W+1)'($signed(ang)) <<< (ezr_pkg::PH_W - ezr_pkg::ANGLE_WIDTH);
                zf = ph;
                nf = 1'b0;
                if (ph > 33'sd1073741824) begin
                    zf = ph - 33'sd2147483648; nf = 1'b1;
                end else if (ph < -33'sd1073741824) begin
                    zf = ph + 33'sd2147483648; nf = 1'b1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_x[a][0] <= ezr_pkg::CORDIC_X0;
                    r_y[a][0] <= '0;
                    r_z[a][0] <= zf;
                    r_neg[a][0] <= nf;
                end
            end
            for (k = 0; k < N; k++) begin : g_it
                always_ff @(posedge i_clk) begin
                    if (adv) begin
                        r_neg[a][k+1] <= r_neg[a][k];
                        if (!r_z[a][k][ezr_pkg::PH_W]) begin
                            r_x[a][k+1] <= r_x[a][k] - (r_y[a][k] >>> k);
                            r_y[a][k+1] <= r_y[a][k] + (r_x[a][k] >>> k);
                            r_z[a][k+1] <= r_z[a][k] - ezr_pkg::atan_of(k);
                        end else begin
                            r_x[a][k+1] <= r_x[a][k] + (r_y[a][k] >>> k);
                            r_y[a][k+1] <= r_y[a][k] - (r_x[a][k] >>> k);
                            r_z[a][k+1] <= r_z[a][k] + ezr_pkg::atan_of(k);
                        end
                    end
                end
            end
            ezr_pkg::t_q30 xc, yc;
            always_comb begin
                xc = r_x[a][N];
                yc = r_y[a][N];
                if (xc > ezr_pkg::ONE_Q30) xc = ezr_pkg::ONE_Q30;
                if (xc < ezr_pkg::NEG_ONE_Q30) xc = ezr_pkg::NEG_ONE_Q30;
                if (yc > ezr_pkg::ONE_Q30) yc = ezr_pkg::ONE_Q30;
                if (yc < ezr_pkg::NEG_ONE_Q30) yc = ezr_pkg::NEG_ONE_Q30;
            end
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_s[a] <= r_neg[a][N] ? -yc : yc;
                    r_c[a] <= r_neg[a][N] ? -xc : xc;
                end
            end
        end
    endgenerate

    // Index 0 roll, 1 pitch, 2 yaw.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // First products.
            r_p1[0] <= ezr_pkg::mul30(r_c[1], r_c[2]);
            r_p1[1] <= ezr_pkg::mul30(r_c[1], r_s[2]);
            r_p1[2] <= ezr_pkg::mul30(r_s[0], r_c[1]);
            r_p1[3] <= ezr_pkg::mul30(r_c[0], r_c[1]);
            r_p1[4] <= ezr_pkg::mul30(r_s[2], r_c[0]);
            r_p1[5] <= ezr_pkg::mul30(r_s[2], r_s[0]);
            r_p1[6] <= ezr_pkg::mul30(r_c[2], r_c[0]);
            r_p1[7] <= ezr_pkg::mul30(r_c[2], r_s[0]);
            r_spr <= ezr_pkg::mul30(r_s[1], r_s[0]);
            r_spc <= ezr_pkg::mul30(r_s[1], r_c[0]);
            r_nsp <= -r_s[1];
            r_sy2 <= ezr_pkg::mul30(r_s[2], r_s[1]);
            r_cy2 <= r_c[2];
            r_q[0] <= r_s[0];
            r_q[1] <= r_c[0];
            // Second products.
            r_t1 <= ezr_pkg::mul30(r_spr, r_cy2);
            r_t2 <= ezr_pkg::mul30(r_spc, r_cy2);
            r_t4 <= ezr_pkg::mul30(r_sy2, r_q[0]);
            r_t5 <= ezr_pkg::mul30(r_sy2, r_q[1]);
            r_a[0] <= r_p1[0];
            r_a[3] <= r_p1[1];
            r_a[6] <= r_nsp;
            r_a[7] <= r_p1[2];
            r_a[8] <= r_p1[3];
            r_a[1] <= r_p1[4];
            r_a[2] <= r_p1[5];
            r_a[4] <= r_p1[6];
            r_a[5] <= r_p1[7];
            // Sums and output rounding.
            r_out.m00 <= ezr_pkg::to_q15(r_a[0]);
            r_out.m01 <= ezr_pkg::to_q15(r_t1 - r_a[1]);
            r_out.m02 <= ezr_pkg::to_q15(r_t2 + r_a[2]);
            r_out.m10 <= ezr_pkg::to_q15(r_a[3]);
            r_out.m11 <= ezr_pkg::to_q15(r_t4 + r_a[4]);
            r_out.m12 <= ezr_pkg::to_q15(r_t5 - r_a[5]);
            r_out.m20 <= ezr_pkg::to_q15(r_a[6]);
            r_out.m21 <= ezr_pkg::to_q15(r_a[7]);
            r_out.m22 <= ezr_pkg::to_q15(r_a[8]);
        end
    end

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data))
        else $error("output changed during stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == (!o_out.valid || o_out.ready))
        else $error("input ready mismatch");
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("pipeline moved during stall");
`endif
endmodule

@@ test/tb_euler_zyx_to_rotation_matrix_top.sv @@
// Testbench for the ZYX Euler angle to rotation matrix block: directed table, random stream.
`timescale 1ns / 100ps

module tb_euler_zyx_to_rotation_matrix_top;

    localparam int LATENCY = 29;
    localparam int N_RANDOM = 1950;

    typedef struct {
        ezr_pkg::t_angles ang;
        bit               has_exp;
        ezr_pkg::t_matrix exp;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    int   n_fail;

    ezr_stream_if #(.T(ezr_pkg::t_angles)) angle_if ();
    ezr_stream_if #(.T(ezr_pkg::t_matrix)) matrix_if ();

    euler_zyx_to_rotation_matrix_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (angle_if.sink),
        .o_out  (matrix_if.source)
    );

    ezr_pkg::t_matrix pending_matrices[$];
    t_row             dir_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint shr_floor(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > 64'sd1073741824) return 64'sd1073741824;
        if (v < -64'sd1073741824) return -64'sd1073741824;
        return v;
    endfunction

    // Sine and cosine of a binary angle in Q2.30 through a 24-step CORDIC.
    function automatic void angle_sincos(ezr_pkg::t_angle a, output longint s,
                                         output longint c);
        longint z, x, y, dx, dy;
        bit     flip;
        logic [31:0] step_angle[24] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
            32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
        z = longint'(a) <<< 16;
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648; flip = 1'b1;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648; flip = 1'b1;
        end
        for (int i = 0; i < 24; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(step_angle[i]);
            end else begin
                x += dx; y -= dy; z += longint'(step_angle[i]);
            end
        end
        x = clamp_unit(x);
        y = clamp_unit(y);
        if (flip) begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return shr_floor(a * b + 64'sd536870912, 30);
    endfunction

    function automatic ezr_pkg::t_q15 round_q15(longint v);
        longint r;
        r = shr_floor(v + 16384, 15);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return ezr_pkg::t_q15'(r);
    endfunction

    function automatic ezr_pkg::t_matrix rotation_of(ezr_pkg::t_angles a);
        longint sr, cr, sp, cp, sy, cy;
        ezr_pkg::t_matrix m;
        angle_sincos(a.roll_angle, sr, cr);
        angle_sincos(a.pitch_angle, sp, cp);
        angle_sincos(a.yaw_angle, sy, cy);
        m.m00 = round_q15(qmul(cp, cy));
        m.m01 = round_q15(qmul(qmul(sp, sr), cy) - qmul(sy, cr));
        m.m02 = round_q15(qmul(qmul(sp, cr), cy) + qmul(sy, sr));
        m.m10 = round_q15(qmul(cp, sy));
        m.m11 = round_q15(qmul(qmul(sy, sp), sr) + qmul(cy, cr));
        m.m12 = round_q15(qmul(qmul(sy, sp), cr) - qmul(cy, sr));
        m.m20 = round_q15(-sp);
        m.m21 = round_q15(qmul(sr, cp));
        m.m22 = round_q15(qmul(cr, cp));
        return m;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic ezr_pkg::t_angles random_angles();
        ezr_pkg::t_angles a;
        int               k;
        a = ezr_pkg::t_angles'(48'({$urandom, $urandom}));
        // Bias some angles toward the quarter-turn folding boundaries and extremes.
        k = $urandom_range(0, 9);
        if (k == 0) begin
            a.pitch_angle = ezr_pkg::t_angle'(16'sd16384 + $signed($urandom_range(0, 4)) - 2);
        end
        if (k == 1) begin
            a.roll_angle = ezr_pkg::t_angle'(-16'sd16384 + $signed($urandom_range(0, 4)) - 2);
        end
        if (k == 2) a.yaw_angle = ($urandom_range(0, 1)) ? 16'sh8000 : 16'sh7FFF;
        return a;
    endfunction

    task automatic add_row(ezr_pkg::t_angle r, ezr_pkg::t_angle p, ezr_pkg::t_angle y,
                           bit known, ezr_pkg::t_matrix m);
        t_row row;
        row.ang = '{roll_angle: r, pitch_angle: p, yaw_angle: y};
        row.has_exp = known;
        row.exp = m;
        dir_rows.push_back(row);
    endtask

    // Valid stays high across back-to-back items and drops only for a gap.
    task automatic send_item(ezr_pkg::t_angles a, ezr_pkg::t_matrix m);
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            angle_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        angle_if.valid <= 1'b1;
        angle_if.data  <= a;
        pending_matrices.push_back(m);
        @(posedge i_clk);
        while (!angle_if.ready) @(posedge i_clk);
    endtask

    // Result side: random back-pressure and compare against the oldest expectation.
    initial begin
        ezr_pkg::t_matrix want;
        ezr_pkg::t_matrix got;
        int               hold;
        matrix_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            hold = gap_len();
            if (hold != 0) begin
                matrix_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            matrix_if.ready <= 1'b1;
            @(posedge i_clk);
            if (i_rst_n && matrix_if.valid && matrix_if.ready) begin
                got = matrix_if.data;
                if (pending_matrices.size() == 0) begin
                    $display("%0t: unexpected matrix item %h", $time, got);
                    n_fail++;
                end else begin
                    want = pending_matrices.pop_front();
                    if (got !== want) begin
                        $display("%0t: matrix mismatch expected %p actual %p", $time, want, got);
                        n_fail++;
                    end
                end
            end
        end
    end

    initial begin
        ezr_pkg::t_matrix m;
        ezr_pkg::t_angles a;
        int               wait_cycles;
        n_fail = 0;
        i_rst_n = 1'b0;
        angle_if.valid = 1'b0;
        angle_if.data = '0;

        // Zero angles give the identity, with +1.0 saturated to 32767.
        m = '{m00: 16'sd32767, m11: 16'sd32767, m22: 16'sd32767, default: 16'sd0};
        add_row(16'sd0, 16'sd0, 16'sd0, 1'b1, m);
        m = '0;
        add_row(16'sd16384, 16'sd0, 16'sd0, 1'b0, m);
        add_row(-16'sd16384, 16'sd0, 16'sd0, 1'b0, m);
        add_row(16'sd0, 16'sd16384, 16'sd0, 1'b0, m);
        add_row(16'sd0, -16'sd16384, 16'sd0, 1'b0, m);
        add_row(16'sd0, 16'sd0, 16'sd16384, 1'b0, m);
        add_row(16'sd0, 16'sd0, -16'sd16384, 1'b0, m);
        add_row(16'sd16385, 16'sd16383, -16'sd16385, 1'b0, m);
        add_row(-16'sd16383, 16'sd16385, 16'sd16383, 1'b0, m);
        add_row(16'sh8000, 16'sh8000, 16'sh8000, 1'b0, m);
        add_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, m);
        add_row(16'sh8000, 16'sh7FFF, 16'sd1, 1'b0, m);
        add_row(-16'sd1, 16'sd1, -16'sd1, 1'b0, m);
        add_row(16'sh5555, 16'shAAAA, 16'sh1234, 1'b0, m);
        add_row(16'shAAAA, 16'sh5555, 16'shEDCB, 1'b0, m);
        add_row(16'sd8192, 16'sd8192, 16'sd8192, 1'b0, m);
        add_row(-16'sd8192, -16'sd24576, 16'sd24576, 1'b0, m);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            m = dir_rows[i].has_exp ? dir_rows[i].exp : rotation_of(dir_rows[i].ang);
            send_item(dir_rows[i].ang, m);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // Drain the pipeline completely once midway through the stream.
            if (n == N_RANDOM / 2) begin
                angle_if.valid <= 1'b0;
                while (pending_matrices.size() != 0) @(posedge i_clk);
            end
            a = random_angles();
            send_item(a, rotation_of(a));
        end
        angle_if.valid <= 1'b0;

        wait_cycles = 0;
        while (pending_matrices.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (pending_matrices.size() != 0) begin
            $display("%0t: %0d matrix items never arrived", $time, pending_matrices.size());
            n_fail++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
